@@ hw/rtl/integer_field_formatter_core_defines.svh @@
// Assertion macros used by the formatter RTL.
`ifndef INTEGER_FIELD_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IFF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/iff_pkg.sv @@
// Types, codes and helpers shared by the integer field formatter.
`timescale 1ns / 1ps
package iff_pkg;

  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int CNT_W      = 7;   // field counts, up to 64
  localparam int DCNT_W     = 5;   // digit count, up to 22

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CONVERSION      = 3'd0,
    REG_LEFT_ADJUST     = 3'd1,
    REG_ZERO_FILL       = 3'd2,
    REG_ALTERNATE_FORM  = 3'd3,
    REG_SIGN_MODE       = 3'd4,
    REG_MIN_WIDTH       = 3'd5,
    REG_DIGIT_PRECISION = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    CONV_SDEC = 3'd0,
    CONV_UDEC = 3'd1,
    CONV_OCT  = 3'd2,
    CONV_HEXL = 3'd3,
    CONV_HEXU = 3'd4
  } conv_e;

  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_SPACE = 2'd1,
    SIGN_PLUS  = 2'd2
  } sign_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CONV,
    F_CLASS,
    F_SIZE,
    F_PUSH
  } front_state_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] digit_precision;  // two's complement
    logic [CFG_DATA_W-1:0] min_width;
    logic [1:0]            sign_mode;
    logic                  alternate_form;
    logic                  zero_fill;
    logic                  left_adjust;
    logic [2:0]            conversion;
  } cfg_t;

  // Layout of one field, handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  lead_cnt;
    logic [1:0]        pre_cnt;
    logic [7:0]        pre_first;
    logic [7:0]        pre_last;
    logic [CNT_W-1:0]  zero_cnt;
    logic [DCNT_W-1:0] dig_cnt;
    logic              upper;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

@@ hw/rtl/iff_if.sv @@
// Channel interfaces: input value, output characters, register writes.
`timescale 1ns / 1ps
interface iff_in_if #(parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface iff_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

interface iff_cfg_if;
  import iff_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/iff_front.sv @@
// Front: takes a value, converts it to digits and sizes the field layout.
`timescale 1ns / 1ps
module iff_front #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_FIELD  = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  iff_in_if.sink                              in_i,
  input  iff_pkg::cfg_t                       cfg_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output iff_pkg::job_t                       job_o,
  output logic [4*((VALUE_BITS+2)/3)-1:0]     digits_o
);
  import iff_pkg::*;

  localparam int DIG_MAX = (VALUE_BITS + 2) / 3;
  localparam int SRC_W   = 4 * DIG_MAX;
  localparam int MAG_W   = ((VALUE_BITS + 3) / 4) * 4;
  localparam int ITERS   = MAG_W / 4;
  localparam int ITER_W  = $clog2(ITERS);

  front_state_e state_q, state_d;

  logic [MAG_W-1:0]  mag_q, mag_step;
  logic [SRC_W-1:0]  bcd_q, bcd_step;
  logic [ITER_W-1:0] iter_q;
  logic              neg_q;
  logic              nz_q;
  logic [SRC_W-1:0]  dvec_q, dvec_sel;
  logic [DCNT_W-1:0] ndig_q, ndig;
  logic [CNT_W-1:0]  zpad_q, zpad;
  logic [1:0]        plen_q, plen;
  logic [7:0]        pfirst_q, pfirst, plast_q, plast;

  conv_e                 conv;
  logic                  is_dec;
  logic                  accept;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag_in;
  logic [SRC_W-1:0]      src;
  logic signed [CNT_W-1:0] prec;
  logic signed [CNT_W-1:0] ndig_s;
  logic [7:0]            body;
  logic [7:0]            wid;
  logic [7:0]            span;
  logic [CNT_W-1:0]      fill;

  // Codes 5 to 7 behave as unsigned decimal
  always_comb begin
    if (cfg_i.conversion > CONV_HEXU) begin
      conv = CONV_UDEC;
    end else begin
      conv = conv_e'(cfg_i.conversion);
    end
    is_dec = (conv == CONV_SDEC) || (conv == CONV_UDEC);
  end

  always_comb begin
    neg_in = (conv == CONV_SDEC) && in_i.value[VALUE_BITS-1];
    mag_in = neg_in ? (VALUE_BITS'(0) - in_i.value) : in_i.value;
  end

  // Four double-dabble steps per cycle
  always_comb begin
    bcd_step = bcd_q;
    mag_step = mag_q;
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < DIG_MAX; k++) begin
        if (bcd_step[4*k +: 4] >= 4'd5) begin
          bcd_step[4*k +: 4] = bcd_step[4*k +: 4] + 4'd3;
        end
      end
      bcd_step = {bcd_step[SRC_W-2:0], mag_step[MAG_W-1]};
      mag_step = {mag_step[MAG_W-2:0], 1'b0};
    end
  end

  assign src = SRC_W'(mag_q);

  always_comb begin
    dvec_sel = '0;
    for (int k = 0; k < DIG_MAX; k++) begin
      unique case (conv)
        CONV_OCT:             dvec_sel[4*k +: 4] = {1'b0, src[3*k +: 3]};
        CONV_HEXL, CONV_HEXU: dvec_sel[4*k +: 4] = src[4*k +: 4];
        default:              dvec_sel[4*k +: 4] = bcd_q[4*k +: 4];
      endcase
    end
  end

  // Significant digit count, at least one
  always_comb begin
    ndig = DCNT_W'(1);
    for (int k = 0; k < DIG_MAX; k++) begin
      if (dvec_q[4*k +: 4] != 4'd0) begin
        ndig = DCNT_W'(k + 1);
      end
    end
    prec   = $signed(cfg_i.digit_precision);
    ndig_s = $signed({2'b00, ndig});
    zpad   = (prec > ndig_s) ? CNT_W'(prec - ndig_s) : '0;
  end

  always_comb begin
    plen   = 2'd0;
    pfirst = CH_ZERO;
    plast  = CH_ZERO;
    if (conv == CONV_SDEC) begin
      if (neg_q) begin
        plen  = 2'd1;
        plast = CH_MINUS;
      end else if (cfg_i.sign_mode == SIGN_SPACE) begin
        plen  = 2'd1;
        plast = CH_SPACE;
      end else if (cfg_i.sign_mode != SIGN_NONE) begin
        plen  = 2'd1;
        plast = CH_PLUS;
      end
    end
    if (cfg_i.alternate_form && nz_q) begin
      if (conv == CONV_OCT && zpad == '0) begin
        plen  = 2'd1;
        plast = CH_ZERO;
      end else if (conv == CONV_HEXL || conv == CONV_HEXU) begin
        plen   = 2'd2;
        pfirst = CH_ZERO;
        plast  = (conv == CONV_HEXU) ? CH_UX : CH_LX;
      end
    end
  end

  // Field layout from the sized body
  always_comb begin
    body = 8'(plen_q) + 8'(zpad_q) + 8'(ndig_q);
    wid  = {1'b0, cfg_i.min_width};
    fill = (wid > body) ? CNT_W'(wid - body) : '0;
    span = (wid > body) ? wid : body;
    job_o.total     = (span > 8'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : CNT_W'(span);
    job_o.pre_cnt   = plen_q;
    job_o.pre_first = pfirst_q;
    job_o.pre_last  = plast_q;
    job_o.dig_cnt   = ndig_q;
    job_o.upper     = (conv == CONV_HEXU);
    priority if (cfg_i.zero_fill) begin
      job_o.lead_cnt = '0;
      job_o.zero_cnt = fill + zpad_q;
    end else if (!cfg_i.left_adjust) begin
      job_o.lead_cnt = fill;
      job_o.zero_cnt = zpad_q;
    end else begin
      job_o.lead_cnt = '0;
      job_o.zero_cnt = zpad_q;
    end
  end

  assign digits_o = dvec_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (in_i.valid) state_d = is_dec ? F_CONV : F_CLASS;
      F_CONV:  if (iter_q == '0) state_d = F_CLASS;
      F_CLASS: state_d = F_SIZE;
      F_SIZE:  state_d = F_PUSH;
      F_PUSH:  if (job_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_i.ready  = (state_q == F_IDLE);
    job_valid_o = (state_q == F_PUSH);
    accept      = (state_q == F_IDLE) && in_i.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        iter_q <= ITER_W'(ITERS - 1);
      end else if (state_q == F_CONV) begin
        iter_q <= iter_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q <= MAG_W'(mag_in);
      bcd_q <= '0;
      neg_q <= neg_in;
      nz_q  <= |in_i.value;
    end else if (state_q == F_CONV) begin
      mag_q <= mag_step;
      bcd_q <= bcd_step;
    end
    if (state_q == F_CLASS) begin
      dvec_q <= dvec_sel;
    end
    if (state_q == F_SIZE) begin
      ndig_q   <= ndig;
      zpad_q   <= zpad;
      plen_q   <= plen;
      pfirst_q <= pfirst;
      plast_q  <= plast;
    end
  end

endmodule

@@ hw/rtl/iff_queue.sv @@
// Two-entry queue between the front and the back.
`timescale 1ns / 1ps
module iff_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);
  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/iff_back.sv @@
// Back: walks the field layout and sends one character per transfer.
`timescale 1ns / 1ps
module iff_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  output logic                            job_ready_o,
  input  iff_pkg::job_t                   job_i,
  input  logic [4*((VALUE_BITS+2)/3)-1:0] digits_i,
  iff_out_if.source                       out_o
);
  import iff_pkg::*;

  localparam int DIG_MAX   = (VALUE_BITS + 2) / 3;
  localparam int SRC_W     = 4 * DIG_MAX;
  localparam int DIG_IDX_W = $clog2(DIG_MAX);

  logic              active_q, active_d;
  logic [CNT_W-1:0]  lead_q, lead_d;
  logic [1:0]        pre_q, pre_d;
  logic [CNT_W-1:0]  zero_q, zero_d;
  logic [DCNT_W-1:0] dig_q, dig_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [7:0]        pfirst_q, plast_q;
  logic              upper_q;
  logic [SRC_W-1:0]  dvec_q;
  logic              ovalid_q, ovalid_d;
  logic [7:0]        ochar_q, ochar_d;
  logic              olast_q, olast_d;

  logic              adv, fire, load;
  logic [DCNT_W-1:0] dig_pos;
  logic [DIG_IDX_W-1:0] dig_idx;
  logic [3:0]        digit;
  logic [7:0]        ch;

  assign dig_pos = dig_q - 1'b1;
  assign dig_idx = dig_pos[DIG_IDX_W-1:0];
  assign digit   = dvec_q[{dig_idx, 2'b00} +: 4];

  always_comb begin
    adv  = !ovalid_q || out_o.ready;
    fire = active_q && adv;
    load = job_valid_i && (!active_q || (fire && rem_q == CNT_W'(1)));
    job_ready_o = load;
  end

  // Character from the first segment not yet used up; trailing spaces last
  always_comb begin
    lead_d = lead_q;
    pre_d  = pre_q;
    zero_d = zero_q;
    dig_d  = dig_q;
    priority if (lead_q != '0) begin
      ch     = CH_SPACE;
      lead_d = lead_q - 1'b1;
    end else if (pre_q != 2'd0) begin
      ch    = (pre_q == 2'd2) ? pfirst_q : plast_q;
      pre_d = pre_q - 1'b1;
    end else if (zero_q != '0) begin
      ch     = CH_ZERO;
      zero_d = zero_q - 1'b1;
    end else if (dig_q != '0) begin
      ch    = digit_char(digit, upper_q);
      dig_d = dig_q - 1'b1;
    end else begin
      ch = CH_SPACE;
    end
  end

  always_comb begin
    active_d = active_q;
    rem_d    = rem_q;
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    if (adv) begin
      ovalid_d = active_q;
      ochar_d  = ch;
      olast_d  = (rem_q == CNT_W'(1));
    end
    if (fire) begin
      rem_d = rem_q - 1'b1;
      if (rem_q == CNT_W'(1)) active_d = 1'b0;
    end
    if (load) begin
      active_d = 1'b1;
      rem_d    = job_i.total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
      rem_q    <= '0;
      lead_q   <= '0;
      pre_q    <= 2'd0;
      zero_q   <= '0;
      dig_q    <= '0;
    end else begin
      active_q <= active_d;
      ovalid_q <= ovalid_d;
      rem_q    <= rem_d;
      if (load) begin
        lead_q <= job_i.lead_cnt;
        pre_q  <= job_i.pre_cnt;
        zero_q <= job_i.zero_cnt;
        dig_q  <= job_i.dig_cnt;
      end else if (fire) begin
        lead_q <= lead_d;
        pre_q  <= pre_d;
        zero_q <= zero_d;
        dig_q  <= dig_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ochar_q <= ochar_d;
    olast_q <= olast_d;
    if (load) begin
      pfirst_q <= job_i.pre_first;
      plast_q  <= job_i.pre_last;
      upper_q  <= job_i.upper;
      dvec_q   <= digits_i;
    end
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.out_char = ochar_q;
  assign out_o.last     = olast_q;

endmodule

@@ hw/rtl/integer_field_formatter_core.sv @@
// Flow: input transfer, then the front states F_CONV (decimal only, the BCD converter), F_CLASS,
// F_SIZE and F_PUSH, then the two-entry queue and the registered output stage; octal and hex skip F_CONV.
// Throughput: one character per cycle at the output while out_o.ready holds; the front takes
// no new value until its item is pushed to the queue, and an item holds the output for its field length.
// Reset: registers return to signed decimal, no flags, width 0, precision not given;
// the front, queue and output stage come up empty.
`timescale 1ns / 1ps
`include "integer_field_formatter_core_defines.svh"
module integer_field_formatter_core #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_FIELD  = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  iff_in_if.sink    in_i,
  iff_out_if.source out_o,
  iff_cfg_if.sink   cfg_i
);
  import iff_pkg::*;

  localparam int DIG_W  = 4 * ((VALUE_BITS + 2) / 3);
  localparam int JOB_W  = $bits(job_t);
  localparam int QDAT_W = JOB_W + DIG_W;
  localparam logic signed [CFG_DATA_W-1:0] PREC_MIN = -7'sd1;
  localparam logic signed [CFG_DATA_W-1:0] PREC_MAX = CFG_DATA_W'(MAX_FIELD - 2);
  localparam logic [CFG_DATA_W-1:0]        WIDTH_MAX = CFG_DATA_W'(MAX_FIELD);

  cfg_t              cfg_q;
  logic              job_valid, job_ready;
  job_t              job;
  logic [DIG_W-1:0]  digits;
  logic              q_valid, q_ready;
  logic [QDAT_W-1:0] q_data;
  job_t              q_job;
  logic [DIG_W-1:0]  q_digits;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conversion      <= CONV_SDEC;
      cfg_q.left_adjust     <= 1'b0;
      cfg_q.zero_fill       <= 1'b0;
      cfg_q.alternate_form  <= 1'b0;
      cfg_q.sign_mode       <= SIGN_NONE;
      cfg_q.min_width       <= '0;
      cfg_q.digit_precision <= PREC_MIN;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_CONVERSION:     cfg_q.conversion     <= cfg_i.data[2:0];
        REG_LEFT_ADJUST:    cfg_q.left_adjust    <= cfg_i.data[0];
        REG_ZERO_FILL:      cfg_q.zero_fill      <= cfg_i.data[0];
        REG_ALTERNATE_FORM: cfg_q.alternate_form <= cfg_i.data[0];
        REG_SIGN_MODE:      cfg_q.sign_mode      <= cfg_i.data[1:0];
        REG_MIN_WIDTH: begin
          cfg_q.min_width <= (cfg_i.data > WIDTH_MAX) ? WIDTH_MAX : cfg_i.data;
        end
        REG_DIGIT_PRECISION: begin
          priority if ($signed(cfg_i.data) < PREC_MIN) begin
            cfg_q.digit_precision <= PREC_MIN;
          end else if ($signed(cfg_i.data) > PREC_MAX) begin
            cfg_q.digit_precision <= PREC_MAX;
          end else begin
            cfg_q.digit_precision <= cfg_i.data;
          end
        end
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  iff_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_FIELD  (MAX_FIELD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job),
    .digits_o    (digits)
  );

  iff_queue #(
    .DATA_W (QDAT_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  ({job, digits}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign q_job    = job_t'(q_data[QDAT_W-1:DIG_W]);
  assign q_digits = q_data[DIG_W-1:0];

  iff_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .digits_i    (q_digits),
    .out_o       (out_o)
  );

  `IFF_ASSERT_NEXT(a_front_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "front took a second value while busy")
  `IFF_ASSERT_NOW(a_job_not_empty, job_valid && job_ready, job.dig_cnt != '0 && job.total != '0, "queued field has no characters")
  `IFF_ASSERT_NOW(a_precision_clamped, 1'b1, $signed(cfg_q.digit_precision) >= PREC_MIN && $signed(cfg_q.digit_precision) <= PREC_MAX, "precision register out of range")
  `IFF_ASSERT_NOW(a_width_clamped, 1'b1, cfg_q.min_width <= WIDTH_MAX, "width register out of range")

endmodule
